// ===== sv/tdpb_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpb_pkg
// Shared constants and types for the tail drop packet buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpb_pkg;

  localparam int unsigned DepthDef     = 64;
  localparam int unsigned TimeWidthDef = 32;

  localparam int unsigned CfgW = 7;
  localparam logic [CfgW-1:0] BufferSizeRst = 7'd64;

  // Per-cycle control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic shift;  // every cell takes its right neighbor's finish time (the end cell takes zero)
    logic push;   // the tail cell takes the new finish time
  } chain_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/tdpb_cell.sv =====
// ----------------------------------------------------------------------------
// tdpb_cell
// One slot of the finish time queue. It either takes its neighbor's value
// when the queue advances or the new finish time when it is the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpb_cell #(
  parameter int unsigned TIME_WIDTH = tdpb_pkg::TimeWidthDef
) (
  input  wire                       clk_i,
  input  tdpb_pkg::chain_ctrl_t     ctrl_i,
  input  wire                       tail_i,
  input  wire  [TIME_WIDTH-1:0]     nbr_i,
  input  wire  [TIME_WIDTH-1:0]     wdata_i,
  output logic [TIME_WIDTH-1:0]     finish_o
);
  import tdpb_pkg::*;

  logic [TIME_WIDTH-1:0] finish_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      finish_q <= nbr_i;
    end else if (ctrl_i.push && tail_i) begin
      finish_q <= wdata_i;
    end
  end

  assign finish_o = finish_q;

endmodule

`default_nettype wire

// ===== sv/tdpb_chain.sv =====
// ----------------------------------------------------------------------------
// tdpb_chain
// Row of finish time cells. Cell zero is the front of the queue; the row
// moves toward it by one cell whenever the front packet retires.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpb_chain #(
  parameter int unsigned DEPTH      = tdpb_pkg::DepthDef,
  parameter int unsigned TIME_WIDTH = tdpb_pkg::TimeWidthDef,
  localparam int unsigned CntW      = $clog2(DEPTH + 1)
) (
  input  wire                       clk_i,
  input  tdpb_pkg::chain_ctrl_t     ctrl_i,
  input  wire  [CntW-1:0]           count_i,
  input  wire  [TIME_WIDTH-1:0]     wdata_i,
  output logic [TIME_WIDTH-1:0]     front_o
);
  import tdpb_pkg::*;

  logic [TIME_WIDTH-1:0] finish [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [TIME_WIDTH-1:0] nbr;
    logic                  tail;

    if (i == DEPTH - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = finish[i+1];
    end

    // The next free slot is the one whose position equals the fill count.
    assign tail = (count_i == CntW'(i));

    tdpb_cell #(
      .TIME_WIDTH(TIME_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .tail_i  (tail),
      .nbr_i   (nbr),
      .wdata_i (wdata_i),
      .finish_o(finish[i])
    );
  end

  assign front_o = finish[0];

endmodule

`default_nettype wire

// ===== sv/tail_drop_packet_buffer_top.sv =====
// ----------------------------------------------------------------------------
// tail_drop_packet_buffer_top
// Single server fed by a finite buffer with tail drop.
//
//   channel   direction  handshake               payload
//   packet    in         start high, busy low    arrival_time_i, process_time_i,
//                                                last_packet_i
//   result    out        done_o for one cycle    dropped_o, start_time_o
//   config    in         cfg_we_i                cfg_wdata_i (buffer size)
//
// A packet takes R + 2 cycles from accept to the next accept, where R is the
// number of buffered packets it retires: one cycle per retired packet at the
// front cell, one cycle for the accept or drop decision, and one cycle in
// which the registered result is shown while the next packet may be taken.
// Reset clears the fill count and the last finish time and sets the buffer
// size to 64; the cells themselves are not cleared. The result side cannot
// stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tail_drop_packet_buffer_top #(
  parameter int unsigned DEPTH      = tdpb_pkg::DepthDef,
  parameter int unsigned TIME_WIDTH = tdpb_pkg::TimeWidthDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire  [TIME_WIDTH-1:0]        arrival_time_i,
  input  wire  [TIME_WIDTH-1:0]        process_time_i,
  input  wire                          last_packet_i,
  output logic                         done_o,
  output logic                         dropped_o,
  output logic [TIME_WIDTH-1:0]        start_time_o,
  input  wire                          cfg_we_i,
  input  wire  [tdpb_pkg::CfgW-1:0]    cfg_wdata_i
);
  import tdpb_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > CfgW) ? CntW : CfgW;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                state_q;
  logic [CntW-1:0]       count_q;
  logic [TIME_WIDTH-1:0] last_finish_q;
  logic [TIME_WIDTH-1:0] arrival_q;
  logic [TIME_WIDTH-1:0] proc_q;
  logic [TIME_WIDTH-1:0] begin_q;
  logic                  last_q;
  logic [CfgW-1:0]       buffer_size_q;
  logic                  done_q;
  logic                  dropped_q;
  logic [TIME_WIDTH-1:0] start_time_q;

  logic [TIME_WIDTH-1:0] front;
  logic [TIME_WIDTH:0]   sum;
  logic [TIME_WIDTH-1:0] finish;
  logic                  retire;
  logic                  has_room;
  chain_ctrl_t           ctrl;

  // Finish times are sorted, so retiring from the front until the first
  // later finish matches retiring every entry at or before the arrival.
  assign retire   = (count_q != '0) && (front <= arrival_q);
  assign has_room = (CmpW'(count_q) < CmpW'(buffer_size_q)) &&
                    (CmpW'(count_q) < CmpW'(DEPTH));

  assign sum    = {1'b0, begin_q} + {1'b0, proc_q};
  assign finish = sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];

  assign ctrl.shift = (state_q == ST_RUN) && retire;
  assign ctrl.push  = (state_q == ST_RUN) && !retire && has_room;

  tdpb_chain #(
    .DEPTH     (DEPTH),
    .TIME_WIDTH(TIME_WIDTH)
  ) u_chain (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .count_i(count_q),
    .wdata_i(finish),
    .front_o(front)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      last_finish_q <= '0;
      arrival_q     <= '0;
      proc_q        <= '0;
      begin_q       <= '0;
      last_q        <= 1'b0;
      done_q        <= 1'b0;
      dropped_q     <= 1'b0;
      start_time_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            arrival_q <= arrival_time_i;
            proc_q    <= process_time_i;
            last_q    <= last_packet_i;
            begin_q   <= (arrival_time_i > last_finish_q) ? arrival_time_i
                                                         : last_finish_q;
            state_q   <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (retire) begin
            count_q <= count_q - 1'b1;
          end else begin
            done_q       <= 1'b1;
            dropped_q    <= !has_room;
            start_time_q <= has_room ? begin_q : '0;
            if (last_q) begin
              count_q       <= '0;
              last_finish_q <= '0;
            end else if (has_room) begin
              count_q       <= count_q + 1'b1;
              last_finish_q <= finish;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_size_q <= BufferSizeRst;
    end else if (cfg_we_i) begin
      buffer_size_q <= cfg_wdata_i;
    end
  end

  assign busy         = (state_q == ST_RUN);
  assign done_o       = done_q;
  assign dropped_o    = dropped_q;
  assign start_time_o = start_time_q;

endmodule

`default_nettype wire

// ===== sv/tdpb_checker.sv =====
// ----------------------------------------------------------------------------
// tdpb_checker
// Port-level checks of the packet and result beats of the buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpb_checker #(
  parameter int unsigned TIME_WIDTH = tdpb_pkg::TimeWidthDef
) (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  start,
  input wire                  busy,
  input wire                  done_o,
  input wire                  dropped_o,
  input wire [TIME_WIDTH-1:0] start_time_o
);

  // An accepted beat keeps the block busy and shows no result yet.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !done_o)
    else $error("accepted beat did not make the block busy");

  // Whenever the block leaves busy, the result beat appears in that cycle.
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result beat");

  // No result appears unless a beat was in flight.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !start |=> !done_o)
    else $error("result beat without an accepted packet");

  // A dropped packet reports a zero start time.
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && dropped_o |-> start_time_o == '0)
    else $error("dropped packet with nonzero start time");

endmodule

bind tail_drop_packet_buffer_top tdpb_checker #(
  .TIME_WIDTH(TIME_WIDTH)
) u_tdpb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .dropped_o   (dropped_o),
  .start_time_o(start_time_o)
);

`default_nettype wire

// ===== verif/tb_tail_drop_packet_buffer_top.sv =====
// ----------------------------------------------------------------------------
// tb_tail_drop_packet_buffer_top
// Self-checking bench for the tail drop packet buffer. A driver presents
// packets from a backlog. A monitor keeps its own model of the finish-time
// queue, predicts the drop flag and start time of every accepted packet, and
// compares each result strobe against the oldest prediction. Buffer size
// changes only between phases, once the block has gone quiet.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tail_drop_packet_buffer_top;
  import tdpb_pkg::*;

  localparam int unsigned SettleCycles = 4;
  localparam int unsigned LimitCycles  = 1_000_000;

  typedef enum logic [1:0] {
    ReqPacket,
    ReqDrain,
    ReqSize
  } req_kind_e;

  typedef struct {
    req_kind_e        kind;
    logic [31:0]      arrival;
    logic [31:0]      service;
    logic             last;
    logic [CfgW-1:0]  size;
  } packet_req_t;

  typedef struct packed {
    logic        dropped;
    logic [31:0] begin_at;
  } service_t;

  logic            clk_i;
  logic            rst_n;
  logic            pkt_start     = 1'b0;
  logic            dut_busy;
  logic [31:0]     arrival_q     = '0;
  logic [31:0]     process_q     = '0;
  logic            last_q        = 1'b0;
  logic            done;
  logic            got_dropped;
  logic [31:0]     got_start;
  logic            size_we       = 1'b0;
  logic [CfgW-1:0] size_wdata    = '0;

  packet_req_t packet_backlog[$];
  service_t    expected_service[$];

  // Model of the buffer: a ring of finish times, its fill and the last finish.
  logic [31:0]     finish_cells [DepthDef];
  int unsigned     ring_head     = 0;
  int unsigned     ring_fill     = 0;
  logic [31:0]     tail_finish   = '0;
  logic [CfgW-1:0] size_reg      = BufferSizeRst;

  logic        beat_taken   = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_left    = 0;
  int unsigned cycle_count  = 0;
  int unsigned fault_count  = 0;
  int unsigned accepted_beats, drops_seen, full_hits, sat_count, size_writes;

  logic        nxt_start;
  logic        nxt_we;
  packet_req_t req;
  service_t    want;

  tail_drop_packet_buffer_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .start          (pkt_start),
    .busy           (dut_busy),
    .arrival_time_i (arrival_q),
    .process_time_i (process_q),
    .last_packet_i  (last_q),
    .done_o         (done),
    .dropped_o      (got_dropped),
    .start_time_o   (got_start),
    .cfg_we_i       (size_we),
    .cfg_wdata_i    (size_wdata)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  task automatic log_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("[%0t] %s", $time, msg);
  endtask

  // Retire what has finished by the arrival, then queue or drop the packet.
  function automatic service_t serve_packet(logic [31:0] arrival, logic [31:0] svc,
                                            logic last);
    service_t    res;
    int unsigned cap;
    logic [32:0] sum;
    logic [31:0] fin;
    res = '0;
    cap = (size_reg < DepthDef) ? size_reg : DepthDef;
    while (ring_fill > 0 && finish_cells[ring_head] <= arrival) begin
      ring_head = (ring_head + 1) % DepthDef;
      ring_fill--;
    end
    if (ring_fill < cap) begin
      res.begin_at = (arrival > tail_finish) ? arrival : tail_finish;
      sum = {1'b0, res.begin_at} + {1'b0, svc};
      fin = sum[32] ? '1 : sum[31:0];
      if (sum[32]) sat_count++;
      finish_cells[(ring_head + ring_fill) % DepthDef] = fin;
      ring_fill++;
      tail_finish = fin;
      if (ring_fill == DepthDef) full_hits++;
    end else begin
      res.dropped = 1'b1;
    end
    if (last) begin
      ring_fill   = 0;
      ring_head   = 0;
      tail_finish = '0;
    end
    return res;
  endfunction

  task automatic push_packet(logic [31:0] arrival, logic [31:0] svc, logic last);
    packet_req_t r;
    r = '{kind: ReqPacket, arrival: arrival, service: svc, last: last, size: '0};
    packet_backlog.insert(packet_backlog.size(), r);
  endtask

  task automatic push_size(logic [CfgW-1:0] size);
    packet_req_t r;
    r = '{kind: ReqSize, arrival: '0, service: '0, last: 1'b0, size: size};
    packet_backlog.insert(packet_backlog.size(), r);
  endtask

  task automatic push_drain();
    packet_req_t r;
    r = '{kind: ReqDrain, arrival: '0, service: '0, last: 1'b0, size: '0};
    packet_backlog.insert(packet_backlog.size(), r);
  endtask

  // One batch of packets ending on the last flag. The mode sets how hard the
  // buffer is loaded: heavy fills it, light keeps it shallow, top runs near the
  // end of the time range, wild takes large random jumps.
  task automatic gen_batch(int unsigned len);
    logic [31:0] t;
    logic [32:0] nxt;
    logic [31:0] svc;
    int unsigned mode, step_max, svc_lo, svc_hi, roll;
    mode = $urandom_range(0, 3);
    t = ($urandom_range(0, 9) == 0) ? '0 : $urandom();
    case (mode)
      0: begin
        step_max = 4;
        svc_lo   = 5;
        svc_hi   = 60;
      end
      1: begin
        step_max = 40;
        svc_lo   = 0;
        svc_hi   = 10;
      end
      2: begin
        t        = 32'hFFFF_FFFF - $urandom_range(0, 2000);
        step_max = 20;
        svc_lo   = 0;
        svc_hi   = 500;
      end
      default: begin
        step_max = 1 << 20;
        svc_lo   = 0;
        svc_hi   = 1 << 21;
      end
    endcase
    for (int unsigned i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        // Arrival that goes backwards.
        t = (t > 50) ? t - $urandom_range(1, 50) : '0;
      end else if (roll < 5) begin
        t = $urandom();
      end else begin
        nxt = {1'b0, t} + $urandom_range(0, step_max);
        t = nxt[32] ? 32'hFFFF_FFFF : nxt[31:0];
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) svc = '0;
      else if (roll < 8) svc = 32'hFFFF_FFFF;
      else if (roll < 10) svc = $urandom();
      else svc = $urandom_range(svc_lo, svc_hi);
      push_packet(t, svc, i == len - 1);
    end
  endtask

  initial begin
    int unsigned phase_sizes[10];
    int unsigned phase_len, made, len;
    phase_sizes = '{64, 2, 0, 1, 127, 3, 0, 100, 5, 64};
    phase_sizes[6] = $urandom_range(0, 127);

    // Directed: default size of 64, then sizes zero, one, above depth and two.
    push_packet(32'd0, 32'd0, 1'b0);
    push_packet(32'd0, 32'd5, 1'b0);
    push_packet(32'd1, 32'hFFFF_FFFF, 1'b0);
    push_packet(32'hFFFF_FFFF, 32'd1, 1'b1);
    push_size(7'd0);
    push_packet(32'd10, 32'd3, 1'b0);
    push_packet(32'd20, 32'd0, 1'b1);
    push_size(7'd1);
    push_packet(32'd100, 32'd50, 1'b0);
    push_packet(32'd120, 32'd10, 1'b0);
    push_packet(32'd150, 32'd7, 1'b0);
    push_packet(32'd140, 32'd1, 1'b0);
    push_packet(32'd157, 32'd2, 1'b1);
    push_size(7'd127);
    push_packet(32'd5, 32'd10, 1'b0);
    push_packet(32'd5, 32'd10, 1'b0);
    push_packet(32'd6, 32'd0, 1'b0);
    push_packet(32'd30, 32'd0, 1'b0);
    push_packet(32'd30, 32'd4, 1'b1);
    push_size(7'd2);
    push_packet(32'd0, 32'd100, 1'b0);
    push_packet(32'd0, 32'd100, 1'b0);
    push_packet(32'd0, 32'd100, 1'b0);
    push_packet(32'd200, 32'd1, 1'b1);

    foreach (phase_sizes[p]) begin
      push_size(phase_sizes[p][CfgW-1:0]);
      phase_len = (phase_sizes[p] == 0) ? 40 : 175;
      made = 0;
      while (made < phase_len) begin
        len = $urandom_range(1, 90);
        if (len > phase_len - made) len = phase_len - made;
        gen_batch(len);
        made += len;
        // Halfway through, hold the sender until the block has answered all.
        if (made >= phase_len / 2 && made - len < phase_len / 2) push_drain();
      end
    end

    rst_n = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    while (packet_backlog.size() > 0 || pkt_start || expected_service.size() > 0)
      @(posedge clk_i);
    repeat (2 * SettleCycles) @(posedge clk_i);
    if (expected_service.size() > 0)
      log_fault($sformatf("%0d results never arrived", expected_service.size()));

    $display("Covered %0d packets over %0d buffer sizes: %0d dropped, %0d saturated finishes,",
             accepted_beats, size_writes, drops_seen, sat_count);
    $display("buffer full at depth %0d times; %0d faults found.", full_hits, fault_count);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Driver: a beat leaves once taken; sizes and pauses wait for a quiet block.
  always @(negedge clk_i) begin
    if (rst_n) begin
      if (!pkt_start || beat_taken) begin
        nxt_start = 1'b0;
        nxt_we    = 1'b0;
        if (idle_left > 0) begin
          idle_left--;
        end else if (packet_backlog.size() > 0) begin
          req = packet_backlog[0];
          case (req.kind)
            ReqPacket: begin
              // A calm stretch in the middle of the run keeps the sender busy.
              if (!(accepted_beats >= 700 && accepted_beats < 1000) &&
                  $urandom_range(0, 99) < 4) begin
                idle_left = $urandom_range(0, 3);
              end else begin
                arrival_q <= req.arrival;
                process_q <= req.service;
                last_q    <= req.last;
                nxt_start = 1'b1;
                void'(packet_backlog.pop_front());
              end
            end
            ReqDrain: begin
              if (expected_service.size() == 0) void'(packet_backlog.pop_front());
            end
            default: begin
              if (expected_service.size() == 0 && quiet_cycles >= SettleCycles &&
                  !dut_busy) begin
                size_wdata <= req.size;
                nxt_we = 1'b1;
                void'(packet_backlog.pop_front());
              end
            end
          endcase
        end
        pkt_start <= nxt_start;
        size_we   <= nxt_we;
      end
    end
  end

  // Monitor: check the result first, since it always belongs to an older beat.
  always @(posedge clk_i) begin
    beat_taken = 1'b0;
    if (rst_n) begin
      if (done) begin
        if (expected_service.size() == 0) begin
          log_fault($sformatf("result with nothing pending: dropped=%0b start=%0h",
                              got_dropped, got_start));
        end else begin
          want = expected_service.pop_front();
          if (got_dropped !== want.dropped)
            log_fault($sformatf("dropped: expected %0b, got %0b", want.dropped,
                                got_dropped));
          if (got_start !== want.begin_at)
            log_fault($sformatf("start: expected %h, got %h", want.begin_at,
                                got_start));
        end
        if (got_dropped === 1'b1) drops_seen++;
      end
      if (size_we) begin
        size_reg = size_wdata;
        size_writes++;
      end
      if (pkt_start && !dut_busy) begin
        beat_taken = 1'b1;
        expected_service.insert(expected_service.size(),
                                serve_packet(arrival_q, process_q, last_q));
        accepted_beats++;
      end
      if (expected_service.size() == 0 && !pkt_start && !size_we) quiet_cycles++;
      else quiet_cycles = 0;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("Run stopped at the cycle limit with %0d results pending.",
               expected_service.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/tdpb_pkg.sv
sv/tdpb_cell.sv
sv/tdpb_chain.sv
sv/tail_drop_packet_buffer_top.sv
sv/tdpb_checker.sv
verif/tb_tail_drop_packet_buffer_top.sv
